@@ design/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CSMF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csmf check failed");

// next-cycle implication, disabled while reset is asserted
`define CSMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csmf check failed");

`endif

@@ design/csmf_pkg.sv @@
// types and constants of the complex sign matched filter
package csmf_pkg;

  localparam int DATA_W  = 16;
  localparam int SIGN_W  = 32;
  localparam int CFG_A_W = 8;

  localparam logic [SIGN_W-1:0] SIGN_I_RESET = 32'hE307A73A;
  localparam logic [SIGN_W-1:0] SIGN_Q_RESET = 32'h285A57AB;

  localparam logic [CFG_A_W-1:0] REG_IN_PHASE_SIGNS   = 8'd0;
  localparam logic [CFG_A_W-1:0] REG_QUADRATURE_SIGNS = 8'd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_i;
    logic signed [DATA_W-1:0] sample_q;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
  } out_item_t;

  // one tap's contribution, or a partial sum, modulo 2^DATA_W
  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
  } term_t;

  // set bit means coefficient -1
  typedef struct packed {
    logic neg_i;
    logic neg_q;
  } coef_t;

endpackage

@@ design/csmf_tap_cell.sv @@
// one tap cell: holds a delayed sample (when HOLD is set) and forms its signed contribution
module csmf_tap_cell #(
  parameter bit HOLD = 1'b1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  csmf_pkg::in_item_t sample_in,
  input  csmf_pkg::coef_t    coef,
  output csmf_pkg::in_item_t sample_out,
  output csmf_pkg::term_t    term_out
);

  logic [csmf_pkg::DATA_W-1:0] i_ci, q_ci, q_cq, i_cq;
  csmf_pkg::term_t             term_r, term_nxt;

  always_comb begin
    i_ci = coef.neg_i ? ('0 - sample_in.sample_i) : sample_in.sample_i;
    q_ci = coef.neg_i ? ('0 - sample_in.sample_q) : sample_in.sample_q;
    q_cq = coef.neg_q ? ('0 - sample_in.sample_q) : sample_in.sample_q;
    i_cq = coef.neg_q ? ('0 - sample_in.sample_i) : sample_in.sample_i;
    term_nxt.x = i_ci + q_cq;
    term_nxt.y = q_ci - i_cq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
    end
  end

  assign term_out = term_r;

  generate
    if (HOLD) begin : g_hold
      csmf_pkg::in_item_t sample_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sample_r <= '0;
        end else if (en) begin
          sample_r <= sample_in;
        end
      end
      assign sample_out = sample_r;
    end else begin : g_end
      // end of the delay line
      assign sample_out = '0;
    end
  endgenerate

endmodule

@@ design/csmf_add_tree.sv @@
// registered binary adder tree over the tap contributions
module csmf_add_tree #(
  parameter int LEAVES = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            leaf_valid,
  input  csmf_pkg::term_t leaf [LEAVES],
  output logic            root_valid,
  output csmf_pkg::term_t root
);

  localparam int LVL = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int N   = 1 << LVL;

  csmf_pkg::term_t node_r [N-1];
  csmf_pkg::term_t all    [2*N-1];
  logic [LVL-1:0]  vld_r;

  genvar g;
  generate
    for (g = 0; g < N - 1; g++) begin : g_node
      assign all[g] = node_r[g];
      always_ff @(posedge clk) begin
        if (en) begin
          node_r[g].x <= all[2*g+1].x + all[2*g+2].x;
          node_r[g].y <= all[2*g+1].y + all[2*g+2].y;
        end
      end
    end
    for (g = 0; g < N; g++) begin : g_leaf
      if (g < LEAVES) begin : g_used
        assign all[N-1+g] = leaf[g];
      end else begin : g_pad
        assign all[N-1+g] = '0;
      end
    end
  endgenerate

  // valid travels with the sums, deepest level first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r[0] <= leaf_valid;
      for (int d = 1; d < LVL; d++) begin
        vld_r[d] <= vld_r[d-1];
      end
    end
  end

  assign root_valid = vld_r[LVL-1];
  assign root       = node_r[0];

endmodule

@@ design/complex_sign_matched_filter_top.sv @@
// pipeline: one cell stage plus ceil(log2(TAPS)) tree levels, at least one
// throughput: one transaction per cycle; the tree advances as one and holds only
// while a finished result is not taken, and the cells load only accepted samples
// reset (rst_n low, synchronous): delay line cleared, sign words to defaults,
// pipeline emptied
module complex_sign_matched_filter_top #(
  parameter int TAPS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  csmf_pkg::in_item_t                 in_data,
  // correlation output
  output logic                               out_valid,
  input  logic                               out_ready,
  output csmf_pkg::out_item_t                out_data,
  // sign word writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [csmf_pkg::CFG_A_W-1:0]       cfg_index,
  input  logic [csmf_pkg::SIGN_W-1:0]        cfg_data
);

  // pipe advance: blocked only by an untaken result in the output register
  logic advance;
  logic accept;

  // sign words, one bit per tap
  logic [csmf_pkg::SIGN_W-1:0] sign_i_r, sign_i_nxt;
  logic [csmf_pkg::SIGN_W-1:0] sign_q_r, sign_q_nxt;

  // samples walking down the row of cells, entry 0 is the live sample
  csmf_pkg::in_item_t smp [TAPS];
  csmf_pkg::term_t    term [TAPS];
  logic               term_vld_r;
  logic               root_vld;
  csmf_pkg::term_t    root;

  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign accept    = in_valid && advance;
  assign cfg_ready = 1'b1;

  // register write decode, unknown indexes dropped
  always_comb begin
    sign_i_nxt = sign_i_r;
    sign_q_nxt = sign_q_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        csmf_pkg::REG_IN_PHASE_SIGNS:   sign_i_nxt = cfg_data;
        csmf_pkg::REG_QUADRATURE_SIGNS: sign_q_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_i_r <= csmf_pkg::SIGN_I_RESET;
      sign_q_r <= csmf_pkg::SIGN_Q_RESET;
    end else begin
      sign_i_r <= sign_i_nxt;
      sign_q_r <= sign_q_nxt;
    end
  end

  assign smp[0] = in_data;

  genvar k;
  generate
    for (k = 0; k < TAPS; k++) begin : g_cell
      csmf_pkg::coef_t coef;
      // taps past the sign word width keep coefficient +1
      if (k < csmf_pkg::SIGN_W) begin : g_sign
        assign coef.neg_i = sign_i_r[k];
        assign coef.neg_q = sign_q_r[k];
      end else begin : g_plus
        assign coef = '0;
      end

      if (k < TAPS - 1) begin : g_mid
        csmf_tap_cell #(.HOLD(1'b1)) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .en         (accept),
          .sample_in  (smp[k]),
          .coef       (coef),
          .sample_out (smp[k+1]),
          .term_out   (term[k])
        );
      end else begin : g_last
        // oldest tap: nothing further down the line
        csmf_tap_cell #(.HOLD(1'b0)) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .en         (accept),
          .sample_in  (smp[k]),
          .coef       (coef),
          .sample_out (),
          .term_out   (term[k])
        );
      end
    end
  endgenerate

  // cell contributions are valid the cycle after a transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_vld_r <= 1'b0;
    end else if (advance) begin
      term_vld_r <= accept;
    end
  end

  // root of the tree doubles as the output register
  csmf_add_tree #(.LEAVES(TAPS)) u_tree (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .leaf_valid (term_vld_r),
    .leaf       (term),
    .root_valid (root_vld),
    .root       (root)
  );

  assign out_valid      = root_vld;
  assign out_data.out_x = root.x;
  assign out_data.out_y = root.y;

endmodule

@@ design/csmf_checker.sv @@
// port-level checks of the filter top, bound to every instance
`include "assert_macros.svh"

module csmf_props (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input csmf_pkg::out_item_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready
);

  `CSMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `CSMF_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
  `CSMF_ASSERT_NOW(a_ready_on_take, out_valid && out_ready, in_ready)
  `CSMF_ASSERT_NOW(a_cfg_always_taken, cfg_valid, cfg_ready)

endmodule

bind complex_sign_matched_filter_top csmf_props u_csmf_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
